// ----- hw/rtl/lag_pkg.sv -----
// ----------------------------------------------------------------------------
// Life automaton grid package
// Shared constants, item kind codes, state type and memory control struct.
// ----------------------------------------------------------------------------
package lag_pkg;

  // Fixed field widths of the item and result ports.
  localparam int CELL_W = 64;
  localparam int IDX_W  = 6;
  localparam int KIND_W = 2;

  // Default grid size (rows and columns).
  localparam int LAG_GRID_SIZE = 64;

  // B3/S23 rule constants.
  localparam int BIRTH_COUNT = 3;
  localparam int SURVIVE_LOW = 2;

  // Neighbor count width (eight neighbors at most).
  localparam int NBR_CNT_W = 4;

  // Item kind codes.
  localparam logic [KIND_W-1:0] KIND_WRITE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_STEP  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_STEP,
    S_DONE
  } state_t;

  // Enables for the grid memory ports.
  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } mem_ctl_t;

endpackage

// ----- hw/rtl/life_automaton_grid_top.sv -----
// ----------------------------------------------------------------------------
// Life automaton grid top level
// Square B3/S23 cell grid with row write, row read and generation step.
// ----------------------------------------------------------------------------
// The grid holds GRID_SIZE rows of GRID_SIZE one-bit cells in a row memory,
// all dead after reset. Each input transaction carries a kind: a write loads
// one row (columns at GRID_SIZE and above are dropped, rows beyond the grid
// are ignored), a read returns one row (zero beyond the grid), and a step
// advances the whole grid by one generation with cells outside the grid
// counting as dead. Every input transaction produces exactly one output
// transaction that echoes the kind; the row field is zero except for reads.
// Items are handled one at a time: a write or an unused kind goes straight to
// the done state, a read through the read state and a step through the step
// state; the done state loads the output register once it is free. The step
// time is set by the row memory: a step sweeps the rows in order, reading one
// row per cycle into a three-row window, while GRID_SIZE cell lanes compute
// the new row and it is written back two rows behind the read pointer. The
// next input transaction is accepted as soon as the result sits in the output
// register, even if the consumer has not taken it yet.
// ----------------------------------------------------------------------------
module life_automaton_grid_top
  import lag_pkg::*;
#(
  parameter int GRID_SIZE = LAG_GRID_SIZE
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [KIND_W-1:0] in_kind,
  input  logic [IDX_W-1:0]  in_row_index,
  input  logic [CELL_W-1:0] in_row_cells_in,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [CELL_W-1:0] out_row_cells_out,
  output logic [KIND_W-1:0] out_done_kind
);

  localparam int ROW_W = $clog2(GRID_SIZE);
  localparam int CNT_W = $clog2(GRID_SIZE + 2);
  localparam logic [IDX_W:0] GRID_LIM = (IDX_W + 1)'(GRID_SIZE);
  localparam logic [CELL_W-1:0] ROW_MASK =
    (GRID_SIZE >= CELL_W) ? {CELL_W{1'b1}} : ((CELL_W'(1) << GRID_SIZE) - CELL_W'(1));

  state_t state_r, state_nxt;

  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [CELL_W-1:0] prev_r, prev_nxt;
  logic [CELL_W-1:0] cur_r, cur_nxt;
  logic [KIND_W-1:0] pend_kind_r, pend_kind_nxt;
  logic              rd_hit_r, rd_hit_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [CELL_W-1:0] out_cells_r, out_cells_nxt;
  logic [KIND_W-1:0] out_kind_r, out_kind_nxt;

  logic              in_accept;
  logic              row_in_grid;
  logic              out_free;
  logic [CNT_W-1:0]  wb_row;
  logic [CELL_W-1:0] next_row;
  logic [CELL_W-1:0] new_row;
  logic [CELL_W-1:0] rd_data;

  mem_ctl_t          mem_ctl;
  logic [ROW_W-1:0]  wr_addr;
  logic [CELL_W-1:0] wr_data;
  logic [ROW_W-1:0]  rd_addr;

  assign in_ready    = (state_r == S_IDLE);
  assign in_accept   = in_valid && in_ready;
  assign row_in_grid = ({1'b0, in_row_index} < GRID_LIM);
  assign out_free    = !out_valid_r || out_ready;

  // Row being written back during a step trails the read pointer by two.
  assign wb_row   = cnt_r - CNT_W'(2);
  // Past the last row the window is fed with a dead row.
  assign next_row = (cnt_r <= CNT_W'(GRID_SIZE)) ? rd_data : '0;

  lag_grid_mem #(
    .GRID_SIZE (GRID_SIZE)
  ) u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .mem_ctl (mem_ctl),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  lag_row_engine #(
    .GRID_SIZE (GRID_SIZE)
  ) u_engine (
    .prev_row (prev_r),
    .cur_row  (cur_r),
    .next_row (next_row),
    .new_row  (new_row)
  );

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          if (in_kind == KIND_READ) begin
            state_nxt = S_READ;
          end else if (in_kind == KIND_STEP) begin
            state_nxt = S_STEP;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_READ: begin
        state_nxt = S_DONE;
      end
      S_STEP: begin
        if (cnt_r == CNT_W'(GRID_SIZE + 1)) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Datapath and memory control.
  always_comb begin
    mem_ctl       = '0;
    wr_addr       = in_row_index[ROW_W-1:0];
    wr_data       = in_row_cells_in & ROW_MASK;
    rd_addr       = in_row_index[ROW_W-1:0];
    cnt_nxt       = cnt_r;
    prev_nxt      = prev_r;
    cur_nxt       = cur_r;
    pend_kind_nxt = pend_kind_r;
    rd_hit_nxt    = rd_hit_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_cells_nxt = out_cells_r;
    out_kind_nxt  = out_kind_r;

    case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          pend_kind_nxt = in_kind;
          rd_hit_nxt    = (in_kind == KIND_READ) && row_in_grid;
          cnt_nxt       = '0;
          prev_nxt      = '0;
          cur_nxt       = '0;
          mem_ctl.wr_en = (in_kind == KIND_WRITE) && row_in_grid;
          mem_ctl.rd_en = (in_kind == KIND_READ) && row_in_grid;
        end
      end
      S_READ: begin
      end
      S_STEP: begin
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r < CNT_W'(GRID_SIZE)) begin
          mem_ctl.rd_en = 1'b1;
          rd_addr       = cnt_r[ROW_W-1:0];
        end
        if (cnt_r != '0) begin
          prev_nxt = cur_r;
          cur_nxt  = next_row;
        end
        if (cnt_r >= CNT_W'(2)) begin
          mem_ctl.wr_en = 1'b1;
          wr_addr       = wb_row[ROW_W-1:0];
          wr_data       = new_row;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = pend_kind_r;
          out_cells_nxt = rd_hit_r ? rd_data : '0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      rd_hit_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
      rd_hit_r    <= rd_hit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prev_r      <= prev_nxt;
    cur_r       <= cur_nxt;
    pend_kind_r <= pend_kind_nxt;
    out_cells_r <= out_cells_nxt;
    out_kind_r  <= out_kind_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_row_cells_out = out_cells_r;
  assign out_done_kind     = out_kind_r;

endmodule

// ----- hw/rtl/lag_cell_lane.sv -----
// ----------------------------------------------------------------------------
// Life automaton cell lane
// Applies the B3/S23 rule to one cell from its eight neighbors.
// ----------------------------------------------------------------------------
module lag_cell_lane
  import lag_pkg::*;
(
  input  logic       self_cell,
  input  logic [7:0] nbr_cells,
  output logic       next_cell
);

  logic [NBR_CNT_W-1:0] nbr_cnt;

  always_comb begin
    nbr_cnt = '0;
    for (int i = 0; i < 8; i++) begin
      nbr_cnt = nbr_cnt + NBR_CNT_W'(nbr_cells[i]);
    end
  end

  assign next_cell = (nbr_cnt == NBR_CNT_W'(BIRTH_COUNT)) ||
                     (self_cell && (nbr_cnt == NBR_CNT_W'(SURVIVE_LOW)));

endmodule

// ----- hw/rtl/lag_row_engine.sv -----
// ----------------------------------------------------------------------------
// Life automaton row engine
// One cell lane per column; the lane outputs are merged into the new row.
// ----------------------------------------------------------------------------
module lag_row_engine
  import lag_pkg::*;
#(
  parameter int GRID_SIZE = LAG_GRID_SIZE
) (
  input  logic [CELL_W-1:0] prev_row,
  input  logic [CELL_W-1:0] cur_row,
  input  logic [CELL_W-1:0] next_row,
  output logic [CELL_W-1:0] new_row
);

  genvar c;
  generate
    for (c = 0; c < GRID_SIZE; c++) begin : g_lane
      logic [7:0] nbr;
      logic       west_p, west_c, west_n;
      logic       east_p, east_c, east_n;

      // Columns outside the grid count as dead.
      if (c > 0) begin : g_west
        assign west_p = prev_row[c-1];
        assign west_c = cur_row[c-1];
        assign west_n = next_row[c-1];
      end else begin : g_west_edge
        assign west_p = 1'b0;
        assign west_c = 1'b0;
        assign west_n = 1'b0;
      end

      if (c < GRID_SIZE - 1) begin : g_east
        assign east_p = prev_row[c+1];
        assign east_c = cur_row[c+1];
        assign east_n = next_row[c+1];
      end else begin : g_east_edge
        assign east_p = 1'b0;
        assign east_c = 1'b0;
        assign east_n = 1'b0;
      end

      assign nbr = {west_p, prev_row[c], east_p, west_c, east_c,
                    west_n, next_row[c], east_n};

      lag_cell_lane u_lane (
        .self_cell (cur_row[c]),
        .nbr_cells (nbr),
        .next_cell (new_row[c])
      );
    end

    for (c = GRID_SIZE; c < CELL_W; c++) begin : g_unused
      assign new_row[c] = 1'b0;
    end
  endgenerate

endmodule

// ----- hw/rtl/lag_grid_mem.sv -----
// ----------------------------------------------------------------------------
// Life automaton grid memory
// One row per entry, one write and one registered read port, row valid bits.
// ----------------------------------------------------------------------------
module lag_grid_mem
  import lag_pkg::*;
#(
  parameter int GRID_SIZE = LAG_GRID_SIZE,
  localparam int ROW_W    = $clog2(GRID_SIZE)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  mem_ctl_t          mem_ctl,
  input  logic [ROW_W-1:0]  wr_addr,
  input  logic [CELL_W-1:0] wr_data,
  input  logic [ROW_W-1:0]  rd_addr,
  output logic [CELL_W-1:0] rd_data
);

  logic [CELL_W-1:0]    mem [GRID_SIZE];
  logic [GRID_SIZE-1:0] row_vld_r;
  logic [CELL_W-1:0]    mem_q_r;
  logic                 vld_q_r;

  // A row that was never written since reset reads as all dead.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r <= '0;
    end else if (mem_ctl.wr_en) begin
      row_vld_r[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_ctl.rd_en) begin
      mem_q_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_q_r <= 1'b0;
    end else if (mem_ctl.rd_en) begin
      vld_q_r <= row_vld_r[rd_addr];
    end
  end

  assign rd_data = vld_q_r ? mem_q_r : '0;

endmodule

// ----- tb/tb_life_automaton_grid_top.sv -----
// ----------------------------------------------------------------------------
// Life automaton grid testbench
// Drives row writes, row reads, generation steps and the unused kind code
// through the valid/ready input channel. Every result is checked against a
// B3/S23 grid model kept in step with accepted items or a literal answer.
// ----------------------------------------------------------------------------
module tb_life_automaton_grid_top;
  import lag_pkg::*;

  // The bench runs the block at its default grid size.
  localparam int GRID = LAG_GRID_SIZE;

  // Kind code 3 has no meaning in the block: it must leave the grid alone
  // and still return one result that echoes it.
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  localparam logic [CELL_W-1:0] ROW_ALL  = '1;
  localparam logic [CELL_W-1:0] ROW_NONE = '0;

  // Size of the random part and the length of the long consumer stall.
  localparam int RANDOM_ITEM_TARGET = 1550;
  localparam int LONG_HOLD_CYCLES   = 400;
  localparam int DIRECTED_COUNT     = 25;

  // Columns at GRID and above never hold a live cell.
  localparam logic [CELL_W-1:0] ROW_MASK =
    (GRID >= CELL_W) ? ROW_ALL : ((CELL_W'(1) << GRID) - CELL_W'(1));

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [KIND_W-1:0] in_kind = KIND_READ;
  logic [IDX_W-1:0]  in_row_index = '0;
  logic [CELL_W-1:0] in_row_cells_in = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [CELL_W-1:0] out_row_cells_out;
  logic [KIND_W-1:0] out_done_kind;

  // Bench-side companions of the payload. When in_typed is set, the row
  // expected for this transaction is the literal in in_typed_bits rather
  // than the model's answer.
  logic              in_typed = 1'b0;
  logic [CELL_W-1:0] in_typed_bits = '0;

  typedef struct {
    logic [CELL_W-1:0] row_bits;
    logic [KIND_W-1:0] kind;
  } life_result_t;

  typedef struct {
    logic [KIND_W-1:0] kind;
    logic [IDX_W-1:0]  row;
    logic [CELL_W-1:0] bits;
    bit                typed;
    logic [CELL_W-1:0] typed_bits;
  } directed_entry_t;

  // Model of the grid, and results still owed by the block, oldest first.
  logic [CELL_W-1:0] life_grid [GRID];
  life_result_t      expected_rows [$];

  int  mismatch_count = 0;
  int  items_issued = 0;
  int  burst_left = 0;
  bit  hold_off_request = 1'b0;

  // Directed opening. Write, step and unused-kind results are zero by
  // definition, and reads of an empty or freshly written grid are trivial,
  // so those rows carry their answer. Reads after a step go to the model.
  directed_entry_t directed_plan [DIRECTED_COUNT] = '{
    '{KIND_READ,   6'd0,  ROW_NONE,              1'b1, ROW_NONE},
    '{KIND_READ,   6'd63, ROW_NONE,              1'b1, ROW_NONE},
    '{KIND_UNUSED, 6'd63, ROW_ALL,               1'b1, ROW_NONE},
    '{KIND_STEP,   6'd0,  ROW_NONE,              1'b1, ROW_NONE},
    '{KIND_READ,   6'd31, ROW_NONE,              1'b1, ROW_NONE},
    '{KIND_WRITE,  6'd0,  ROW_ALL,               1'b1, ROW_NONE},
    '{KIND_WRITE,  6'd63, ROW_ALL,               1'b1, ROW_NONE},
    '{KIND_READ,   6'd0,  ROW_NONE,              1'b1, ROW_ALL},
    '{KIND_READ,   6'd63, ROW_ALL,               1'b1, ROW_ALL},
    '{KIND_STEP,   6'd63, ROW_ALL,               1'b1, ROW_NONE},
    '{KIND_READ,   6'd0,  ROW_NONE,              1'b0, ROW_NONE},
    '{KIND_READ,   6'd1,  ROW_NONE,              1'b0, ROW_NONE},
    '{KIND_READ,   6'd62, ROW_NONE,              1'b0, ROW_NONE},
    '{KIND_READ,   6'd63, ROW_NONE,              1'b0, ROW_NONE},
    '{KIND_WRITE,  6'd0,  ROW_NONE,              1'b1, ROW_NONE},
    '{KIND_WRITE,  6'd1,  ROW_NONE,              1'b1, ROW_NONE},
    '{KIND_WRITE,  6'd62, ROW_NONE,              1'b1, ROW_NONE},
    '{KIND_WRITE,  6'd63, ROW_NONE,              1'b1, ROW_NONE},
    '{KIND_WRITE,  6'd30, 64'h8000_0000_0000_0001, 1'b1, ROW_NONE},
    '{KIND_WRITE,  6'd31, 64'hC000_0000_0000_0003, 1'b1, ROW_NONE},
    '{KIND_UNUSED, 6'd31, 64'h5555_5555_5555_5555, 1'b1, ROW_NONE},
    '{KIND_STEP,   6'd17, 64'hAAAA_AAAA_AAAA_AAAA, 1'b1, ROW_NONE},
    '{KIND_READ,   6'd30, ROW_NONE,              1'b0, ROW_NONE},
    '{KIND_READ,   6'd31, ROW_NONE,              1'b0, ROW_NONE},
    '{KIND_READ,   6'd32, ROW_NONE,              1'b0, ROW_NONE}
  };

  life_automaton_grid_top #(
    .GRID_SIZE(GRID)
  ) DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_kind          (in_kind),
    .in_row_index     (in_row_index),
    .in_row_cells_in  (in_row_cells_in),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_row_cells_out(out_row_cells_out),
    .out_done_kind    (out_done_kind)
  );

  always #1 clk = ~clk;

  // --------------------------------------------------------------------------
  // Grid model
  // --------------------------------------------------------------------------

  // A neighbor off the edge of the grid is simply dead; there is no wrap.
  function automatic int alive_at(input logic [CELL_W-1:0] bits, input int col);
    if (col < 0 || col >= GRID) return 0;
    return int'(bits[col]);
  endfunction

  // Every cell of the new generation is computed from the old one, so the
  // new rows are built aside and copied in at the end.
  function automatic void advance_generation();
    logic [CELL_W-1:0] next_gen [GRID];
    logic [CELL_W-1:0] above;
    logic [CELL_W-1:0] below;
    logic [CELL_W-1:0] here;
    int                nbr_total;
    for (int r = 0; r < GRID; r++) begin
      above = (r > 0) ? life_grid[r-1] : '0;
      below = (r < GRID - 1) ? life_grid[r+1] : '0;
      here = life_grid[r];
      next_gen[r] = '0;
      for (int c = 0; c < GRID; c++) begin
        nbr_total = 0;
        for (int dc = -1; dc <= 1; dc++) begin
          nbr_total += alive_at(above, c + dc) + alive_at(below, c + dc);
          if (dc != 0) nbr_total += alive_at(here, c + dc);
        end
        // Birth on exactly three; a live cell also survives on two.
        if (nbr_total == BIRTH_COUNT || (here[c] && nbr_total == SURVIVE_LOW))
          next_gen[r][c] = 1'b1;
      end
    end
    for (int r = 0; r < GRID; r++) life_grid[r] = next_gen[r];
  endfunction

  // Applies one transaction to the model and returns the row it should yield.
  function automatic logic [CELL_W-1:0] predict_row_result(
    input logic [KIND_W-1:0] kind,
    input logic [IDX_W-1:0]  row,
    input logic [CELL_W-1:0] bits
  );
    logic [CELL_W-1:0] answer;
    answer = '0;
    case (kind)
      KIND_WRITE: if (int'(row) < GRID) life_grid[row] = bits & ROW_MASK;
      KIND_STEP:  advance_generation();
      KIND_READ:  if (int'(row) < GRID) answer = life_grid[row] & ROW_MASK;
      default: ;
    endcase
    return answer;
  endfunction

  // --------------------------------------------------------------------------
  // Monitors. Both sample at the rising edge, before the bench's own
  // nonblocking updates of that edge take effect.
  // --------------------------------------------------------------------------

  initial begin
    for (int r = 0; r < GRID; r++) life_grid[r] = '0;
  end

  always @(posedge clk) begin : record_accepted_item
    life_result_t owed;
    if (rst_n && in_valid && in_ready) begin
      owed.kind = in_kind;
      owed.row_bits = predict_row_result(in_kind, in_row_index, in_row_cells_in);
      if (in_typed) owed.row_bits = in_typed_bits;
      expected_rows.push_back(owed);
    end
  end

  always @(posedge clk) begin : compare_result
    life_result_t owed;
    if (rst_n && out_valid && out_ready) begin
      if (expected_rows.size() == 0) begin
        $display("%0t: result with nothing expected, actual row %h kind %0d",
                 $time, out_row_cells_out, out_done_kind);
        mismatch_count++;
      end else begin
        owed = expected_rows.pop_front();
        if (out_row_cells_out !== owed.row_bits) begin
          $display("%0t: row_cells_out expected %h actual %h (kind %0d)",
                   $time, owed.row_bits, out_row_cells_out, owed.kind);
          mismatch_count++;
        end
        if (out_done_kind !== owed.kind) begin
          $display("%0t: done_kind expected %0d actual %0d",
                   $time, owed.kind, out_done_kind);
          mismatch_count++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Consumer. Ready follows a mode that changes every stretch of cycles:
  // always ready, coin toss, mostly stalled, or a fixed period. On request
  // from the producer it holds off for a long stretch so the block backs up
  // and drops in_ready while items are still being offered.
  // --------------------------------------------------------------------------
  initial begin : drive_out_ready
    int stall_mode;
    int mode_left;
    int tick;
    stall_mode = 0;
    mode_left = 0;
    tick = 0;
    wait (rst_n);
    forever begin
      @(posedge clk);
      tick++;
      if (hold_off_request) begin
        hold_off_request = 1'b0;
        out_ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
      end else begin
        if (mode_left == 0) begin
          stall_mode = $urandom_range(0, 3);
          mode_left = $urandom_range(10, 150);
        end
        mode_left--;
        case (stall_mode)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom_range(0, 1));
          2: out_ready <= ($urandom_range(0, 3) == 0);
          default: out_ready <= (tick % 5 != 0);
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // Producer helpers
  // --------------------------------------------------------------------------

  // Between transactions the producer runs in bursts. A burst ends in a gap
  // of random length; some bursts are long enough to keep the block busy
  // back to back.
  task automatic pace_sender();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 12);
      gap = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 40)
                                        : $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Offers one transaction and returns at the edge where it was taken.
  task automatic issue_item(
    input logic [KIND_W-1:0] kind,
    input logic [IDX_W-1:0]  row,
    input logic [CELL_W-1:0] bits,
    input bit                typed,
    input logic [CELL_W-1:0] typed_bits
  );
    in_valid <= 1'b1;
    in_kind <= kind;
    in_row_index <= row;
    in_row_cells_in <= bits;
    in_typed <= typed;
    in_typed_bits <= typed_bits;
    do @(posedge clk); while (!in_ready);
    items_issued++;
    pace_sender();
  endtask

  task automatic issue_checked(
    input logic [KIND_W-1:0] kind,
    input int                row,
    input logic [CELL_W-1:0] bits
  );
    issue_item(kind, IDX_W'(row), bits, 1'b0, '0);
  endtask

  // Stops offering and waits for every owed result. It first waits for a clock
  // edge so that the last accepted transaction is already on the list.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_rows.size() != 0) @(posedge clk);
  endtask

  function automatic logic [CELL_W-1:0] random_row_bits();
    logic [CELL_W-1:0] a;
    logic [CELL_W-1:0] b;
    logic [CELL_W-1:0] c;
    a = {$urandom, $urandom};
    b = {$urandom, $urandom};
    c = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0, 1:    return a;
      2, 3, 4: return a & b;
      5, 6:    return a & b & c;
      7:       return '0;
      8:       return '1;
      default: return (CELL_W'(7) << $urandom_range(0, CELL_W - 1)) | (a & b & c);
    endcase
  endfunction

  function automatic logic [CELL_W-1:0] random_ignored_bits();
    return {$urandom, $urandom};
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int span;
    int base;
    int col;
    int steps;
    int first;
    int last;
    bit hold_done;
    bit drain_done;
    logic [CELL_W-1:0] shape [3];

    hold_done = 1'b0;
    drain_done = 1'b0;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < DIRECTED_COUNT; i++)
      issue_item(directed_plan[i].kind, directed_plan[i].row, directed_plan[i].bits,
                 directed_plan[i].typed, directed_plan[i].typed_bits);

    // Random part, organized in episodes. Most episodes seed a region or a
    // known pattern, let it evolve and read it back; the rest are plain
    // noise, clears and whole-grid sweeps.
    while (items_issued - DIRECTED_COUNT < RANDOM_ITEM_TARGET) begin
      if (!hold_done && items_issued - DIRECTED_COUNT >= 300) begin
        hold_off_request = 1'b1;
        hold_done = 1'b1;
      end
      if (!drain_done && items_issued - DIRECTED_COUNT >= 900) begin
        drain_results();
        drain_done = 1'b1;
      end

      case ($urandom_range(0, 19))
        // Random region, evolved for a few generations and read back with
        // a margin of two rows on each side.
        0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10: begin
          span = $urandom_range(3, 10);
          case ($urandom_range(0, 3))
            0: base = 0;
            1: base = GRID - span;
            default: base = $urandom_range(0, GRID - span);
          endcase
          for (int i = 0; i < span; i++)
            issue_checked(KIND_WRITE, base + i, random_row_bits());
          steps = $urandom_range(1, 8);
          for (int i = 0; i < steps; i++) begin
            issue_checked(KIND_STEP, $urandom_range(0, GRID - 1), random_ignored_bits());
            if ($urandom_range(0, 2) == 0)
              issue_checked(KIND_READ, base + $urandom_range(0, span - 1),
                            random_ignored_bits());
          end
          first = (base >= 2) ? base - 2 : 0;
          last = (base + span + 1 < GRID) ? base + span + 1 : GRID - 1;
          for (int r = first; r <= last; r++)
            issue_checked(KIND_READ, r, random_ignored_bits());
        end
        // A small known pattern on a cleared patch, often against an edge
        // or a corner, read back after every generation.
        11, 12, 13: begin
          case ($urandom_range(0, 3))
            0: begin
              shape[0] = CELL_W'(3'b010);
              shape[1] = CELL_W'(3'b100);
              shape[2] = CELL_W'(3'b111);
            end
            1: begin
              shape[0] = CELL_W'(3'b000);
              shape[1] = CELL_W'(3'b111);
              shape[2] = CELL_W'(3'b000);
            end
            2: begin
              shape[0] = CELL_W'(3'b011);
              shape[1] = CELL_W'(3'b110);
              shape[2] = CELL_W'(3'b010);
            end
            default: begin
              shape[0] = CELL_W'(3'b011);
              shape[1] = CELL_W'(3'b011);
              shape[2] = CELL_W'(3'b000);
            end
          endcase
          case ($urandom_range(0, 2))
            0: base = 0;
            1: base = GRID - 3;
            default: base = $urandom_range(0, GRID - 3);
          endcase
          case ($urandom_range(0, 2))
            0: col = 0;
            1: col = GRID - 3;
            default: col = $urandom_range(0, GRID - 3);
          endcase
          first = (base >= 2) ? base - 2 : 0;
          last = (base + 4 < GRID) ? base + 4 : GRID - 1;
          for (int r = first; r <= last; r++)
            issue_checked(KIND_WRITE, r, '0);
          for (int i = 0; i < 3; i++)
            issue_checked(KIND_WRITE, base + i, shape[i] << col);
          steps = $urandom_range(1, 12);
          for (int i = 0; i < steps; i++) begin
            issue_checked(KIND_STEP, $urandom_range(0, GRID - 1), random_ignored_bits());
            for (int r = first; r <= last; r++)
              issue_checked(KIND_READ, r, random_ignored_bits());
          end
        end
        // Noise: any kind, including the unused code, with any payload.
        14, 15, 16: begin
          steps = $urandom_range(5, 20);
          for (int i = 0; i < steps; i++)
            issue_checked(KIND_W'($urandom_range(0, 3)), $urandom_range(0, GRID - 1),
                          random_ignored_bits());
        end
        // Clear part of the grid, now and then all of it.
        17, 18: begin
          if ($urandom_range(0, 3) == 0) begin
            first = 0;
            last = GRID - 1;
          end else begin
            first = $urandom_range(0, GRID - 8);
            last = first + $urandom_range(7, GRID - 1 - first);
          end
          for (int r = first; r <= last; r++)
            issue_checked(KIND_WRITE, r, '0);
        end
        // Read back the whole grid.
        default: begin
          for (int r = 0; r < GRID; r++)
            issue_checked(KIND_READ, r, random_ignored_bits());
        end
      endcase
    end

    // All stimulus is in: wait for the owed results, then give the block a
    // full step time to show any stray result.
    drain_results();
    repeat (GRID + 10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Watchdog: a time limit several times the slowest correct run.
  initial begin : watchdog
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

// ----- life_automaton_grid_top.f -----
hw/rtl/lag_pkg.sv
hw/rtl/lag_cell_lane.sv
hw/rtl/lag_row_engine.sv
hw/rtl/lag_grid_mem.sv
hw/rtl/life_automaton_grid_top.sv
tb/tb_life_automaton_grid_top.sv
